>>> rtl/core/clpw_pkg.sv
// Shared types, codes and constant tables for the character LCD pin sequencer.
// Used by clpw_cfg, clpw_seq and char_lcd_busy_poll_writer; depends on nothing.
package clpw_pkg;

  localparam int TIMER_BITS_DEF = 21;
  localparam int PROD_W         = 21;   // 30 * 16-bit ticks_per_ms fits in 21 bits
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 32;

  // Operation codes carried by a request
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_POLL_CMD = 3'd1;
  localparam logic [2:0] OP_POLL_DAT = 3'd2;
  localparam logic [2:0] OP_RAW_CMD  = 3'd3;
  localparam logic [2:0] OP_INIT     = 3'd4;

  // Register indexes on the configuration port
  localparam logic REG_TICKS_PER_MS = 1'b0;
  localparam logic REG_PULSE_TICKS  = 1'b1;

  localparam logic [15:0] TICKS_PER_MS_RST = 16'd16000;
  localparam logic [7:0]  PULSE_TICKS_RST  = 8'd1;

  localparam logic [7:0] BUSY_MASK  = 8'h80;
  localparam logic [2:0] INIT_LAST  = 3'd6;
  localparam logic [2:0] INIT_POLLS = 3'd3;   // first init step that polls busy

  localparam logic [4:0] MS_STEP0 = 5'd30;
  localparam logic [4:0] MS_STEP1 = 5'd10;
  localparam logic [4:0] MS_STEP2 = 5'd1;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_DELAY        = 3'd1,
    PH_POLL_HI      = 3'd2,
    PH_POLL_LO_BUSY = 3'd3,
    PH_POLL_LO_FREE = 3'd4,
    PH_WRITE_HI     = 3'd5,
    PH_WRITE_LO     = 3'd6
  } phase_e;

  typedef struct packed {
    logic [15:0] ticks_per_ms;
    logic [7:0]  pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic       reg_select;
    logic       read_not_write;
    logic       enable_pin;
    logic [7:0] data_out;
    logic       data_drive;
    logic       ready_res;
    logic       accepted;
  } res_t;

  // Byte sent at each init step; steps past the end repeat the last one
  function automatic logic [7:0] init_byte(input logic [2:0] s);
    logic [7:0] b;
    case (s)
      3'd0:    b = 8'h30;
      3'd1:    b = 8'h30;
      3'd2:    b = 8'h30;
      3'd3:    b = 8'h38;
      3'd4:    b = 8'h06;
      3'd5:    b = 8'h01;
      default: b = 8'h0F;
    endcase
    return b;
  endfunction

  // Delay ahead of an unpolled init step, in ticks (constant multiply)
  function automatic logic [PROD_W-1:0] init_delay(input logic [2:0] s,
                                                   input logic [15:0] tpm);
    logic [4:0] ms;
    case (s)
      3'd0:    ms = MS_STEP0;
      3'd1:    ms = MS_STEP1;
      default: ms = MS_STEP2;
    endcase
    return PROD_W'(tpm) * PROD_W'(ms);
  endfunction

endpackage

>>> rtl/core/char_lcd_busy_poll_writer.sv
// Character LCD busy-poll writer: drives RS, R/W, E and the 8-bit bus of an
// HD44780-style display, one input request per sequencer tick.
// A request's pin levels sit in the result register from the cycle after it
// is accepted. Throughput: one request per cycle while results are taken; a
// result that is not taken stalls the input until it is.
// Reset: asynchronous, active low; sequencer idle, result invalid, config at defaults; result data not reset.
module char_lcd_busy_poll_writer #(
  parameter int TIMER_BITS = clpw_pkg::TIMER_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel: each accepted request is one sequencer tick
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  operation_i,
  input  logic [7:0]                  request_byte_i,
  input  logic [7:0]                  bus_in_i,
  // result channel: pin levels for the tick
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        reg_select_o,
  output logic                        read_not_write_o,
  output logic                        enable_pin_o,
  output logic [7:0]                  data_out_o,
  output logic                        data_drive_o,
  output logic                        ready_res_o,
  output logic                        accepted_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [clpw_pkg::CFG_AW-1:0] paddr,
  input  logic [clpw_pkg::CFG_DW-1:0] pwdata,
  output logic [clpw_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  clpw_pkg::cfg_t cfg;
  clpw_pkg::res_t res_c;
  clpw_pkg::res_t res_q;
  logic           out_valid_q, out_valid_d;
  logic           in_fire;

  // Free the result slot when it is empty or being drained this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  clpw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The sequencer advances only on an accepted request
  clpw_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_fire),
    .operation_i    (operation_i),
    .request_byte_i (request_byte_i),
    .bus_in_i       (bus_in_i),
    .cfg_i          (cfg),
    .res_o          (res_c)
  );

  // Hold the result until taken; load a fresh one on every accept
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_c;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reg_select_o     = res_q.reg_select;
  assign read_not_write_o = res_q.read_not_write;
  assign enable_pin_o     = res_q.enable_pin;
  assign data_out_o       = res_q.data_out;
  assign data_drive_o     = res_q.data_drive;
  assign ready_res_o      = res_q.ready_res;
  assign accepted_o       = res_q.accepted;

endmodule

>>> rtl/core/clpw_cfg.sv
// APB-style configuration registers: ticks_per_ms and pulse_ticks.
// Depends on clpw_pkg.
module clpw_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clpw_pkg::CFG_AW-1:0]   paddr,
  input  logic [clpw_pkg::CFG_DW-1:0]   pwdata,
  output logic [clpw_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output clpw_pkg::cfg_t                cfg_o
);

  logic [15:0] tpm_q;
  logic [7:0]  pulse_q;
  logic        wr_en;
  logic        sel;

  assign pready = 1'b1;
  assign sel    = paddr[2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q   <= clpw_pkg::TICKS_PER_MS_RST;
      pulse_q <= clpw_pkg::PULSE_TICKS_RST;
    end else if (wr_en) begin
      if (sel == clpw_pkg::REG_TICKS_PER_MS) begin
        tpm_q <= pwdata[15:0];
      end else begin
        pulse_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (sel == clpw_pkg::REG_TICKS_PER_MS) begin
      prdata = clpw_pkg::CFG_DW'(tpm_q);
    end else begin
      prdata = clpw_pkg::CFG_DW'(pulse_q);
    end
  end

  assign cfg_o.ticks_per_ms = tpm_q;
  assign cfg_o.pulse_ticks  = pulse_q;

endmodule

>>> rtl/core/clpw_seq.sv
// Pin sequencer state and one-tick step logic: request accept, pin levels,
// timer countdown and phase advance. Depends on clpw_pkg.
module clpw_seq #(
  parameter int TIMER_BITS = clpw_pkg::TIMER_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [2:0]     operation_i,
  input  logic [7:0]     request_byte_i,
  input  logic [7:0]     bus_in_i,
  input  clpw_pkg::cfg_t cfg_i,
  output clpw_pkg::res_t res_o
);

  localparam int CW = (TIMER_BITS > clpw_pkg::PROD_W) ? TIMER_BITS : clpw_pkg::PROD_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
  localparam logic [TIMER_BITS-1:0] TONE = TIMER_BITS'(1);

  clpw_pkg::phase_e      phase_q, phase_d, ph_cur, ph_a;
  logic [TIMER_BITS-1:0] timer_q, timer_d, tmr_a;
  logic [2:0]            step_q, step_d, step_a, step_nx;
  logic [7:0]            byte_q, byte_d, byte_a;
  logic                  isdat_q, isdat_d, isdat_a;
  logic                  polls_q, polls_d, polls_a;
  logic                  init_q, init_d, init_a;
  logic                  ready, acc;
  logic [TIMER_BITS-1:0] plen, len0, len_nx;

  // Clamp a delay product into the timer range, at least one tick
  function automatic logic [TIMER_BITS-1:0] sat_len(input logic [clpw_pkg::PROD_W-1:0] p);
    logic [CW-1:0]         w;
    logic [TIMER_BITS-1:0] r;
    w = CW'(p);
    if (w > CW'(TMAX)) begin
      r = TMAX;
    end else begin
      r = w[TIMER_BITS-1:0];
    end
    if (r == '0) begin
      r = TONE;
    end
    return r;
  endfunction

  always_comb begin
    case (phase_q)
      clpw_pkg::PH_DELAY,
      clpw_pkg::PH_POLL_HI,
      clpw_pkg::PH_POLL_LO_BUSY,
      clpw_pkg::PH_POLL_LO_FREE,
      clpw_pkg::PH_WRITE_HI,
      clpw_pkg::PH_WRITE_LO: ph_cur = phase_q;
      default:               ph_cur = clpw_pkg::PH_IDLE;
    endcase
  end

  assign ready   = (ph_cur == clpw_pkg::PH_IDLE);
  assign plen    = (cfg_i.pulse_ticks == '0) ? TONE : TIMER_BITS'(cfg_i.pulse_ticks);
  assign len0    = sat_len(clpw_pkg::init_delay(3'd0, cfg_i.ticks_per_ms));
  assign step_nx = step_q + 3'd1;
  assign len_nx  = sat_len(clpw_pkg::init_delay(step_nx, cfg_i.ticks_per_ms));

  // Request accept: take it only when idle and the code names a request
  always_comb begin
    ph_a    = ph_cur;
    tmr_a   = timer_q;
    step_a  = step_q;
    byte_a  = byte_q;
    isdat_a = isdat_q;
    polls_a = polls_q;
    init_a  = init_q;
    acc     = 1'b0;
    if (ready && operation_i != clpw_pkg::OP_TICK && operation_i <= clpw_pkg::OP_INIT) begin
      acc = 1'b1;
      if (operation_i == clpw_pkg::OP_INIT) begin
        init_a  = 1'b1;
        step_a  = 3'd0;
        byte_a  = clpw_pkg::init_byte(3'd0);
        isdat_a = 1'b0;
        polls_a = 1'b0;
        ph_a    = clpw_pkg::PH_DELAY;
        tmr_a   = len0;
      end else begin
        init_a  = 1'b0;
        byte_a  = request_byte_i;
        isdat_a = (operation_i == clpw_pkg::OP_POLL_DAT);
        polls_a = (operation_i != clpw_pkg::OP_RAW_CMD);
        ph_a    = polls_a ? clpw_pkg::PH_POLL_HI : clpw_pkg::PH_WRITE_HI;
        tmr_a   = plen;
      end
    end
  end

  // Pin levels for this tick
  always_comb begin
    res_o.data_out  = byte_a;
    res_o.ready_res = ready;
    res_o.accepted  = acc;
    case (ph_a)
      clpw_pkg::PH_POLL_HI,
      clpw_pkg::PH_POLL_LO_BUSY,
      clpw_pkg::PH_POLL_LO_FREE: begin
        res_o.reg_select     = 1'b0;
        res_o.read_not_write = 1'b1;
        res_o.data_drive     = 1'b0;
        res_o.enable_pin     = (ph_a == clpw_pkg::PH_POLL_HI);
      end
      default: begin
        res_o.reg_select     = isdat_a;
        res_o.read_not_write = 1'b0;
        res_o.data_drive     = 1'b1;
        res_o.enable_pin     = (ph_a == clpw_pkg::PH_WRITE_HI);
      end
    endcase
  end

  // Count down and advance the phase when the timer runs out
  always_comb begin
    phase_d = ph_a;
    timer_d = tmr_a;
    step_d  = step_a;
    byte_d  = byte_a;
    isdat_d = isdat_a;
    polls_d = polls_a;
    init_d  = init_a;
    if (ph_a != clpw_pkg::PH_IDLE) begin
      if (tmr_a != '0) begin
        timer_d = tmr_a - TONE;
      end
      if (timer_d == '0) begin
        case (ph_a)
          clpw_pkg::PH_DELAY: begin
            phase_d = polls_a ? clpw_pkg::PH_POLL_HI : clpw_pkg::PH_WRITE_HI;
            timer_d = plen;
          end
          clpw_pkg::PH_POLL_HI: begin
            phase_d = ((bus_in_i & clpw_pkg::BUSY_MASK) != '0) ?
                      clpw_pkg::PH_POLL_LO_BUSY : clpw_pkg::PH_POLL_LO_FREE;
            timer_d = plen;
          end
          clpw_pkg::PH_POLL_LO_BUSY: begin
            phase_d = clpw_pkg::PH_POLL_HI;
            timer_d = plen;
          end
          clpw_pkg::PH_POLL_LO_FREE: begin
            phase_d = clpw_pkg::PH_WRITE_HI;
            timer_d = plen;
          end
          clpw_pkg::PH_WRITE_HI: begin
            phase_d = clpw_pkg::PH_WRITE_LO;
            timer_d = plen;
          end
          default: begin
            if (init_a && step_a < clpw_pkg::INIT_LAST) begin
              step_d  = step_nx;
              byte_d  = clpw_pkg::init_byte(step_nx);
              isdat_d = 1'b0;
              if (step_nx < clpw_pkg::INIT_POLLS) begin
                polls_d = 1'b0;
                phase_d = clpw_pkg::PH_DELAY;
                timer_d = len_nx;
              end else begin
                polls_d = 1'b1;
                phase_d = clpw_pkg::PH_POLL_HI;
                timer_d = plen;
              end
            end else begin
              init_d  = 1'b0;
              phase_d = clpw_pkg::PH_IDLE;
              timer_d = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= clpw_pkg::PH_IDLE;
      timer_q <= '0;
      step_q  <= '0;
      byte_q  <= '0;
      isdat_q <= 1'b0;
      polls_q <= 1'b0;
      init_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      step_q  <= step_d;
      byte_q  <= byte_d;
      isdat_q <= isdat_d;
      polls_q <= polls_d;
      init_q  <= init_d;
    end
  end

endmodule
